### rtl/core/plfm_pkg.sv
// Shared types, constants and helpers for the price level FIFO matcher.
`timescale 1ns / 1ps

package plfm_pkg;

    // Resting order queue and match limits
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH  = 2;
    localparam int CQ_PTR_W    = $clog2(CMDQ_DEPTH);
    localparam int CQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

    // Field widths
    localparam int QTY_W       = 32;
    localparam int ID_W        = 32;
    localparam int PRICE_W     = 32;
    localparam int TOTAL_W     = 40;
    localparam int OCNT_W      = 5;
    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 240;

    // Request codes on the input tuser
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_MATCH  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_ADD_BAD,
        CMD_REMOVE,
        CMD_MATCH,
        CMD_OTHER
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ID_W-1:0]   id;
        logic [QTY_W-1:0]  qty;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SETTLE,
        BK_EMIT
    } t_back_state;

    // Wrapping increment of an order queue pointer
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    // Wrapping increment of a command queue pointer
    function automatic logic [CQ_PTR_W-1:0] cq_inc(input logic [CQ_PTR_W-1:0] p);
        if (p == CQ_PTR_W'(CMDQ_DEPTH - 1))
            return '0;
        return p + CQ_PTR_W'(1);
    endfunction

endpackage

### rtl/core/price_level_fifo_matcher.sv
// Top level of the price level FIFO matcher.
//
// One price level of an order book: add, remove-head and match requests enter on
// the slave stream, are classified in the front end (price check) and wait in a
// two-entry command queue; the back end runs them against a 16-deep queue of
// resting orders and returns results on the master stream, one per request for
// add/remove/other and one per order touched for match (one empty result if none
// is touched), tlast on the final one. In the back end each request is issued,
// then passes execute, head read settle and emit; a match repeats execute, settle
// and emit for each order touched. The settle step is set by the single registered
// read port of the order storage, which must re-read the head entry after every
// pop or write before a result can report the new head. Output back-pressure
// stalls the emit step. No clearing pass follows reset; the block is ready at once.
`timescale 1ns / 1ps

module price_level_fifo_matcher import plfm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PRICE_W-1:0]  i_cfg_wdata,   // level_price
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,     // order_id, order_price, quantity
    input  logic [1:0]          i_s_tuser,     // req_type
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // filled_order_id, fill_qty, order_left, order_done, matched_total,
    // level_total, order_count, head_valid, head_order_id, head_remaining, pad
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic [1:0]          o_m_tuser,     // status
    output logic                o_m_tlast      // last
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic f_push;
    t_cmd f_cmd;
    t_cmd q_cmd;

    plfm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .o_s_tready  (o_s_tready),
        .o_push      (f_push),
        .o_cmd       (f_cmd)
    );

    plfm_cmd_queue u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    plfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### rtl/core/plfm_front.sv
// Front end: holds the level price, accepts requests and classifies them.
`timescale 1ns / 1ps

module plfm_front import plfm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PRICE_W-1:0]  i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // order_id, order_price, quantity
    input  logic [1:0]          i_s_tuser,   // req_type
    input  logic                i_q_full,
    output logic                o_s_tready,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic [PRICE_W-1:0] r_level_price;
    logic [PRICE_W-1:0] w_price;

    // Level price register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_price <= PRICE_W'(1);
        end else if (i_cfg_we) begin
            r_level_price <= i_cfg_wdata;
        end
    end

    assign w_price    = i_s_tdata[63:32];
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    // Classify the request; the price check is settled here
    always_comb begin
        o_cmd.id  = i_s_tdata[31:0];
        o_cmd.qty = i_s_tdata[95:64];
        unique case (i_s_tuser)
            REQ_ADD:    o_cmd.kind = (w_price == r_level_price) ? CMD_ADD : CMD_ADD_BAD;
            REQ_REMOVE: o_cmd.kind = CMD_REMOVE;
            REQ_MATCH:  o_cmd.kind = CMD_MATCH;
            default:    o_cmd.kind = CMD_OTHER;
        endcase
    end

endmodule

### rtl/core/plfm_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module plfm_cmd_queue import plfm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                r_slot [CMDQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr;
    logic [CQ_PTR_W-1:0] r_rd;
    logic [CQ_CNT_W-1:0] r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_cnt == CQ_CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= cq_inc(r_wr);
            if (w_pop)  r_rd <= cq_inc(r_rd);
            if (w_push && !w_pop)
                r_cnt <= r_cnt + CQ_CNT_W'(1);
            else if (w_pop && !w_push)
                r_cnt <= r_cnt - CQ_CNT_W'(1);
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wr] <= i_cmd;
    end

endmodule

### rtl/core/plfm_back.sv
// Back end: order queue, running totals, match walk and result register.
`timescale 1ns / 1ps

module plfm_back import plfm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic [1:0]          o_m_tuser,
    output logic                o_m_tlast
);

    // Order storage, one registered read port at the head pointer
    logic [ID_W-1:0]  mem_id  [QUEUE_DEPTH];
    logic [QTY_W-1:0] mem_rem [QUEUE_DEPTH];
    logic [ID_W-1:0]  r_rd_id;
    logic [QTY_W-1:0] r_rd_rem;

    t_back_state        r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    t_cmd               r_cmd, n_cmd;
    logic [QTY_W-1:0]   r_need, n_need;
    logic [QTY_W-1:0]   r_matched, n_matched;
    logic [NRES_W-1:0]  r_nres, n_nres;

    // Result fields waiting for the head to settle
    t_status            r_st_status, n_st_status;
    logic [ID_W-1:0]    r_st_id, n_st_id;
    logic [QTY_W-1:0]   r_st_fill, n_st_fill;
    logic [QTY_W-1:0]   r_st_left, n_st_left;
    logic               r_st_done, n_st_done;
    logic               r_st_last, n_st_last;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;
    logic [1:0]          r_out_user, n_out_user;
    logic                r_out_last, n_out_last;

    // Memory write port
    logic               w_we;
    logic               w_id_we;
    logic [PTR_W-1:0]   w_addr;
    logic [QTY_W-1:0]   w_rem;

    logic               w_out_free;
    logic               w_hv;
    logic [QTY_W-1:0]   w_take;
    logic [QTY_W-1:0]   w_left;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_hv       = (r_count != '0);
    assign w_take     = (r_rd_rem < r_need) ? r_rd_rem : r_need;
    assign w_left     = r_rd_rem - w_take;

    // Order storage writes and head read
    always_ff @(posedge i_clk) begin
        if (w_we)    mem_rem[w_addr] <= w_rem;
        if (w_id_we) mem_id[w_addr]  <= r_cmd.id;
        r_rd_id  <= mem_id[r_head];
        r_rd_rem <= mem_rem[r_head];
    end

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_total     <= n_total;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_need      <= n_need;
        r_matched   <= n_matched;
        r_st_status <= n_st_status;
        r_st_id     <= n_st_id;
        r_st_fill   <= n_st_fill;
        r_st_left   <= n_st_left;
        r_st_done   <= n_st_done;
        r_st_last   <= n_st_last;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
        r_out_last  <= n_out_last;
    end

    // Next state and datapath
    always_comb begin
        logic more;
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_total     = r_total;
        n_cmd       = r_cmd;
        n_need      = r_need;
        n_matched   = r_matched;
        n_nres      = r_nres;
        n_st_status = r_st_status;
        n_st_id     = r_st_id;
        n_st_fill   = r_st_fill;
        n_st_left   = r_st_left;
        n_st_done   = r_st_done;
        n_st_last   = r_st_last;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_id_we     = 1'b0;
        w_addr      = r_head;
        w_rem       = w_left;
        more        = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_need    = i_cmd.qty;
                    n_matched = '0;
                    n_nres    = '0;
                    n_state   = BK_EXEC;
                end
            end

            BK_EXEC: begin
                // Non-match results carry zero match fields
                n_st_status = ST_OK;
                n_st_id     = '0;
                n_st_fill   = '0;
                n_st_left   = '0;
                n_st_done   = 1'b0;
                n_st_last   = 1'b1;
                unique case (r_cmd.kind)
                    CMD_ADD: begin
                        if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                            n_st_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_id_we = 1'b1;
                            w_addr  = r_tail;
                            w_rem   = r_cmd.qty;
                            n_tail  = ptr_inc(r_tail);
                            n_count = r_count + CNT_W'(1);
                            n_total = r_total + {{(TOTAL_W-QTY_W){1'b0}}, r_cmd.qty};
                        end
                    end
                    CMD_ADD_BAD: begin
                        n_st_status = ST_MISMATCH;
                    end
                    CMD_REMOVE: begin
                        if (!w_hv) begin
                            n_st_status = ST_EMPTY;
                        end else begin
                            n_total = r_total - {{(TOTAL_W-QTY_W){1'b0}}, r_rd_rem};
                            n_head  = ptr_inc(r_head);
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    CMD_MATCH: begin
                        // Nothing to touch on the first step: one empty result
                        if (!(r_nres == '0 && (!w_hv || r_need == '0))) begin
                            w_we      = 1'b1;
                            n_need    = r_need - w_take;
                            n_matched = r_matched + w_take;
                            n_total   = r_total - {{(TOTAL_W-QTY_W){1'b0}}, w_take};
                            n_nres    = r_nres + NRES_W'(1);
                            if (w_left == '0) begin
                                n_head  = ptr_inc(r_head);
                                n_count = r_count - CNT_W'(1);
                            end
                            more = (n_count != '0) && (n_need != '0) &&
                                   (n_nres < NRES_W'(MAX_RESULTS));
                            n_st_id   = r_rd_id;
                            n_st_fill = w_take;
                            n_st_left = w_left;
                            n_st_done = (w_left == '0);
                            n_st_last = !more;
                        end else begin
                            n_matched = '0;
                        end
                    end
                    default: begin
                        n_st_status = ST_OK;
                    end
                endcase
                n_state = BK_SETTLE;
            end

            BK_SETTLE: begin
                // Head read picks up the new head pointer
                n_state = BK_EMIT;
            end

            BK_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_st_status;
                    n_out_last  = r_st_last;
                    n_out_data  = {1'b0,
                                   w_hv ? r_rd_rem : {QTY_W{1'b0}},
                                   w_hv ? r_rd_id  : {ID_W{1'b0}},
                                   w_hv,
                                   OCNT_W'(r_count),
                                   r_total,
                                   (r_cmd.kind == CMD_MATCH) ? r_matched : {QTY_W{1'b0}},
                                   r_st_done,
                                   r_st_left,
                                   r_st_fill,
                                   r_st_id};
                    n_state     = r_st_last ? BK_IDLE : BK_EXEC;
                end
            end

            default: n_state = BK_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("resting count above queue depth");

    a_ptr_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(QUEUE_DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with resting count");

    a_exec_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EXEC) |=> (r_state == BK_SETTLE))
        else $error("result emitted without head settle cycle");

    a_nres_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("match touched too many orders");

endmodule

### tb/price_level_fifo_matcher_tb.sv
// Self-checking testbench for the price level FIFO matcher: directed and random requests.
`timescale 1ns / 1ps

module price_level_fifo_matcher_tb;
    import plfm_pkg::*;

    // Request type with no defined meaning; the block answers with a plain ok
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 92;

    // Flow control modes
    localparam int FLOW_FREE     = 0;
    localparam int FLOW_SRC_IDLE = 1;
    localparam int FLOW_SNK_IDLE = 2;
    localparam int FLOW_BOTH     = 3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } t_book_req;

    typedef struct {
        t_status     status;
        logic [31:0] filled_id;
        logic [31:0] fill_qty;
        logic [31:0] order_left;
        logic        order_done;
        logic [31:0] matched;
        logic [39:0] level_total;
        logic [4:0]  order_count;
        logic        head_valid;
        logic [31:0] head_id;
        logic [31:0] head_rem;
        logic        last;
    } t_fill_report;

    // Tracks the resting queue and holds the results each request should produce
    class level_scoreboard;
        logic [31:0]  level_price;
        logic [31:0]  ids [QUEUE_DEPTH];
        logic [31:0]  rem [QUEUE_DEPTH];
        int           head;
        int           tail;
        int           count;
        logic [39:0]  total;
        int           errors;
        t_fill_report expected_fills[$];

        function new();
            level_price = 32'd1;
            head        = 0;
            tail        = 0;
            count       = 0;
            total       = '0;
            errors      = 0;
        endfunction

        function void set_price(logic [31:0] p);
            level_price = p;
        endfunction

        function int pending();
            return expected_fills.size();
        endfunction

        // Append one expected result at the back of the list
        function void expect_fill(t_fill_report f);
            expected_fills = {expected_fills, f};
        endfunction

        // Result fields plus the level view after the state update
        function t_fill_report snapshot(t_status st, logic [31:0] oid, logic [31:0] fill,
                                        logic [31:0] left, logic done, logic [31:0] matched,
                                        logic last);
            t_fill_report f;
            f.status      = st;
            f.filled_id   = oid;
            f.fill_qty    = fill;
            f.order_left  = left;
            f.order_done  = done;
            f.matched     = matched;
            f.level_total = total;
            f.order_count = count[4:0];
            f.head_valid  = (count != 0);
            f.head_id     = (count != 0) ? ids[head] : '0;
            f.head_rem    = (count != 0) ? rem[head] : '0;
            f.last        = last;
            return f;
        endfunction

        function void pop_head();
            head  = (head + 1) % QUEUE_DEPTH;
            count = count - 1;
        endfunction

        // Apply one accepted request and queue the results it causes
        function void predict_fills(t_book_req r);
            t_status     st;
            logic [31:0] matched;
            logic [31:0] avail;
            logic [31:0] take;
            logic [31:0] left;
            logic [31:0] oid;
            logic        done;
            logic        more;
            int          n;
            st = ST_OK;
            case (r.kind)
                REQ_ADD: begin
                    // price check wins over the full check
                    if (r.price != level_price) begin
                        st = ST_MISMATCH;
                    end else if (count >= QUEUE_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        ids[tail] = r.id;
                        rem[tail] = r.qty;
                        tail      = (tail + 1) % QUEUE_DEPTH;
                        count     = count + 1;
                        total     = total + {8'd0, r.qty};
                    end
                    expect_fill(snapshot(st, '0, '0, '0, 1'b0, '0, 1'b1));
                end
                REQ_REMOVE: begin
                    if (count == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        total = total - {8'd0, rem[head]};
                        pop_head();
                    end
                    expect_fill(snapshot(st, '0, '0, '0, 1'b0, '0, 1'b1));
                end
                REQ_MATCH: begin
                    matched = '0;
                    n       = 0;
                    while (count != 0 && matched < r.qty && n < MAX_RESULTS) begin
                        avail     = rem[head];
                        take      = (avail < r.qty - matched) ? avail : r.qty - matched;
                        oid       = ids[head];
                        left      = avail - take;
                        done      = (left == 0);
                        rem[head] = left;
                        matched   = matched + take;
                        total     = total - {8'd0, take};
                        if (done)
                            pop_head();
                        more = (count != 0) && (matched < r.qty) && (n + 1 < MAX_RESULTS);
                        expect_fill(snapshot(ST_OK, oid, take, left, done, matched, !more));
                        n++;
                    end
                    // nothing touched: a single empty fill
                    if (n == 0)
                        expect_fill(snapshot(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1));
                end
                default: begin
                    expect_fill(snapshot(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1));
                end
            endcase
        endfunction

        function void cmp(string name, logic [39:0] want, logic [39:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        // Compare one output transaction with the oldest pending expectation
        function void check_fill(t_fill_report got);
            t_fill_report want;
            if (expected_fills.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, expected none, actual id %0h fill %0h",
                             $time, got.filled_id, got.fill_qty);
                return;
            end
            want = expected_fills.pop_front();
            cmp("status", want.status, got.status);
            cmp("filled_order_id", want.filled_id, got.filled_id);
            cmp("fill_qty", want.fill_qty, got.fill_qty);
            cmp("order_left", want.order_left, got.order_left);
            cmp("order_done", want.order_done, got.order_done);
            cmp("matched_total", want.matched, got.matched);
            cmp("level_total", want.level_total, got.level_total);
            cmp("order_count", want.order_count, got.order_count);
            cmp("head_valid", want.head_valid, got.head_valid);
            cmp("head_order_id", want.head_id, got.head_id);
            cmp("head_remaining", want.head_rem, got.head_rem);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [PRICE_W-1:0]  i_cfg_wdata = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic [1:0]          i_s_tuser   = '0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [1:0]          o_m_tuser;
    logic                o_m_tlast;

    level_scoreboard sb;
    int              flow_mode = FLOW_FREE;
    int              quiet_cycles = 0;

    price_level_fifo_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check accepted transactions, then pick the next ready
    always @(posedge i_clk) begin
        t_fill_report got;
        int           stall_pct;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.filled_id   = o_m_tdata[31:0];
            got.fill_qty    = o_m_tdata[63:32];
            got.order_left  = o_m_tdata[95:64];
            got.order_done  = o_m_tdata[96];
            got.matched     = o_m_tdata[128:97];
            got.level_total = o_m_tdata[168:129];
            got.order_count = o_m_tdata[173:169];
            got.head_valid  = o_m_tdata[174];
            got.head_id     = o_m_tdata[206:175];
            got.head_rem    = o_m_tdata[238:207];
            got.status      = t_status'(o_m_tuser);
            got.last        = o_m_tlast;
            sb.check_fill(got);
        end
        stall_pct = (flow_mode == FLOW_SNK_IDLE) ? 79 : (flow_mode == FLOW_BOTH) ? 20 : 0;
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("price_level_fifo_matcher_tb: done, errors");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_req(logic [1:0] kind, logic [31:0] id, logic [31:0] price,
                            logic [31:0] qty);
        t_book_req r;
        int        gap_pct;
        r.kind  = kind;
        r.id    = id;
        r.price = price;
        r.qty   = qty;
        gap_pct = (flow_mode == FLOW_SRC_IDLE) ? 79 : (flow_mode == FLOW_BOTH) ? 20 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {qty, price, id};
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_fills(r);
    endtask

    // Stop offering, let every pending result come out, then a short pause
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_price(logic [31:0] p);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_price(p);
    endtask

    // Random request mix: mostly well-formed adds and matches, some noise
    task automatic send_random();
        logic [1:0]  kind;
        logic [31:0] price;
        logic [31:0] qty;
        int          pick;
        int          sel;
        pick  = $urandom_range(0, 99);
        sel   = $urandom_range(0, 99);
        price = sb.level_price;
        qty   = $urandom();
        if (pick < 44) begin
            kind = REQ_ADD;
            if (sel < 8)
                qty = '0;
            else if (sel < 75)
                qty = $urandom_range(1, 200);
            else if (sel >= 92)
                qty = '1;
        end else if (pick < 50) begin
            // wrong price, either far off or one tick away
            kind = REQ_ADD;
            if (sel < 50) begin
                do price = $urandom(); while (price == 0 || price == sb.level_price);
            end else begin
                price = (sb.level_price == '1) ? sb.level_price - 1 : sb.level_price + 1;
            end
        end else if (pick < 62) begin
            kind  = REQ_REMOVE;
            price = $urandom();
        end else if (pick < 97) begin
            kind  = REQ_MATCH;
            price = $urandom();
            if (sel < 8)
                qty = '0;
            else if (sel < 65)
                qty = $urandom_range(1, 150);
            else if (sel < 88)
                qty = $urandom_range(1, 1500);
            else if (sel < 94)
                qty = '1;
        end else begin
            kind  = REQ_UNKNOWN;
            price = $urandom();
        end
        send_req(kind, $urandom(), price, qty);
    endtask

    task automatic run_phase(int mode, int n_items);
        flow_mode = mode;
        repeat (n_items) send_random();
        drain();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue cases, zero quantities, extremes, full queue
        send_req(REQ_REMOVE, 32'h0, 32'h1, 32'h0);
        send_req(REQ_MATCH, 32'h0, 32'h1, 32'd100);
        send_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 32'h0, 32'h1, 32'h0);
        send_req(REQ_MATCH, 32'h0, 32'h1, 32'h0);
        send_req(REQ_ADD, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        send_req(REQ_MATCH, 32'h1234_5678, 32'h1, 32'd1);
        send_req(REQ_REMOVE, 32'h0, 32'h1, 32'h0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_req(REQ_ADD, 32'hA5A5_0000 ^ (32'h1 << (2 * i)), 32'h1,
                     (i == 3) ? 32'h0 : 32'(7 * i + 1));
        send_req(REQ_ADD, 32'hDEAD_BEEF, 32'h1, 32'd5);
        send_req(REQ_ADD, 32'hDEAD_BEEF, 32'h2, 32'd5);
        send_req(REQ_MATCH, 32'h0, 32'h1, 32'hFFFF_FFFF);
        drain();

        // Random phases across price settings and flow control modes
        run_phase(FLOW_FREE, PHASE_ITEMS);
        write_price(32'hFFFF_FFFF);
        run_phase(FLOW_SRC_IDLE, PHASE_ITEMS);
        write_price($urandom_range(2, 32'hFFFF_FFFE));
        run_phase(FLOW_SNK_IDLE, PHASE_ITEMS);
        write_price($urandom_range(2, 32'hFFFF_FFFE));
        run_phase(FLOW_BOTH, PHASE_ITEMS);
        write_price(32'h1);
        run_phase(FLOW_FREE, PHASE_ITEMS);

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("price_level_fifo_matcher_tb: done, clean");
        else
            $display("price_level_fifo_matcher_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/core/plfm_pkg.sv
rtl/core/plfm_front.sv
rtl/core/plfm_cmd_queue.sv
rtl/core/plfm_back.sv
rtl/core/price_level_fifo_matcher.sv
tb/price_level_fifo_matcher_tb.sv
